FILE: design/dotq_pkg.sv
`default_nettype none
package dotq_pkg;

  localparam int QueueDepthDef = 16;
  localparam int MaxResults    = 16;
  localparam logic [15:0] MinIntervalRst = 16'd1000;

  typedef enum logic [1:0] {
    ActTick  = 2'd0,
    ActAdd   = 2'd1,
    ActClear = 2'd2,
    ActNop   = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    StIdle,
    StAddRd,
    StAddCmp,
    StClrRd,
    StClrCmp,
    StTickRd,
    StTickCmp,
    StEmitRd,
    StEmitOut,
    StResp
  } state_e;

  typedef struct packed {
    logic [63:0] deadline;
    logic [7:0]  tag;
    logic [15:0] arg;
  } entry_t;

endpackage
`default_nettype wire

FILE: design/deadline_ordered_timer_queue_unit.sv
// Channel | valid       | stall       | payload
// input   | in_valid_i  | in_stall_o  | action_i offset_i event_tag_i event_arg_i
// output  | out_valid_o | out_stall_i | fired_* last_o status_o compare_value_o armed_o
// config  | min_interval_we_i (no stall)  | min_interval_i
//
// One word at a time. The queue is a ring in one single-port memory with a
// registered read, so every entry visited is first read, then used.
// Add: moves entries later than the new one up, then writes the new entry.
// Full add and nop: a response only. Clear: packs the entries of other tags.
// Tick: reads due entries from the head, then one word per fired event, or
// one when none fire. Reset is asynchronous; the memory needs no clearing.
// Output stalls hold the sequencer only where a result is waiting to be loaded.
`default_nettype none
module deadline_ordered_timer_queue_unit #(
  parameter int QueueDepth = dotq_pkg::QueueDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        min_interval_we_i,
  input  wire logic [15:0] min_interval_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [63:0] offset_i,
  input  wire logic [7:0]  event_tag_i,
  input  wire logic [15:0] event_arg_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             fired_valid_o,
  output logic [7:0]       fired_tag_o,
  output logic [15:0]      fired_arg_o,
  output logic             last_o,
  output logic             status_o,
  output logic [63:0]      compare_value_o,
  output logic             armed_o
);

  localparam int AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CW = $clog2(QueueDepth + 1);
  localparam int MW = $clog2(dotq_pkg::MaxResults + 1);
  localparam int JW = (CW > MW) ? CW : MW;

  dotq_pkg::entry_t mem [QueueDepth];
  dotq_pkg::entry_t rdata_q;

  dotq_pkg::state_e state_q, state_d;
  logic [63:0] now_q, now_d, floor_q, cmp_q, cmp_d, tgt_q, tgt_d;
  logic [15:0] min_q, arg_q, arg_d;
  logic [7:0]  tag_q, tag_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] occ_q, occ_d;
  logic [JW-1:0] idx_q, idx_d, wr_q, wr_d;
  logic st_q, st_d;

  logic        ov_q, ov_d, ofv_q, ofv_d, olast_q, olast_d, ost_q, ost_d;
  logic        oarm_q, oarm_d;
  logic [7:0]  otag_q, otag_d;
  logic [15:0] oarg_q, oarg_d;
  logic [63:0] ocmp_q, ocmp_d;

  logic accept, can_load, due;
  logic we, re;
  logic [AW-1:0] waddr, raddr;
  dotq_pkg::entry_t wdata, new_entry;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [JW-1:0] l);
    logic [JW:0] s;
    s = (JW+1)'(head) + (JW+1)'(l);
    if (s >= (JW+1)'(QueueDepth)) begin
      s = s - (JW+1)'(QueueDepth);
    end
    return AW'(s);
  endfunction

  function automatic logic [63:0] pick_cmp(input logic [63:0] flr,
                                           input logic [63:0] target);
    return (flr >= target) ? flr : target;
  endfunction

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != dotq_pkg::StIdle);
  assign can_load  = !ov_q || !out_stall_i;
  assign due       = (rdata_q.deadline <= now_q) &&
                     (idx_q < JW'(dotq_pkg::MaxResults));
  assign new_entry = '{deadline: tgt_q, tag: tag_q, arg: arg_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dotq_pkg::StIdle: begin
        if (accept) begin
          case (dotq_pkg::action_e'(action_i))
            dotq_pkg::ActTick:  state_d = dotq_pkg::StTickRd;
            dotq_pkg::ActAdd:   state_d = (occ_q == CW'(QueueDepth)) ?
                                          dotq_pkg::StResp : dotq_pkg::StAddRd;
            dotq_pkg::ActClear: state_d = dotq_pkg::StClrRd;
            default:            state_d = dotq_pkg::StResp;
          endcase
        end
      end
      dotq_pkg::StAddRd:   state_d = (idx_q == '0) ? dotq_pkg::StResp
                                                   : dotq_pkg::StAddCmp;
      dotq_pkg::StAddCmp:  state_d = (rdata_q.deadline > tgt_q) ? dotq_pkg::StAddRd
                                                                 : dotq_pkg::StResp;
      dotq_pkg::StClrRd:   state_d = (idx_q == JW'(occ_q)) ? dotq_pkg::StResp
                                                           : dotq_pkg::StClrCmp;
      dotq_pkg::StClrCmp:  state_d = dotq_pkg::StClrRd;
      dotq_pkg::StTickRd:  state_d = (idx_q == JW'(occ_q)) ? dotq_pkg::StEmitRd
                                                           : dotq_pkg::StTickCmp;
      dotq_pkg::StTickCmp: state_d = due ? dotq_pkg::StTickRd : dotq_pkg::StEmitRd;
      dotq_pkg::StEmitRd: begin
        if (idx_q != '0) begin
          state_d = dotq_pkg::StEmitOut;
        end else if (can_load) begin
          state_d = dotq_pkg::StIdle;
        end
      end
      dotq_pkg::StEmitOut: begin
        if (can_load) begin
          state_d = (wr_q == idx_q - JW'(1)) ? dotq_pkg::StIdle : dotq_pkg::StEmitRd;
        end
      end
      dotq_pkg::StResp:    if (can_load) state_d = dotq_pkg::StIdle;
      default:             state_d = dotq_pkg::StIdle;
    endcase
  end

  // datapath and memory control
  always_comb begin
    now_d = now_q;   cmp_d = cmp_q;   tgt_d = tgt_q;
    tag_d = tag_q;   arg_d = arg_q;   head_d = head_q;
    occ_d = occ_q;   idx_d = idx_q;   wr_d = wr_q;   st_d = st_q;
    we = 1'b0;  re = 1'b0;
    waddr = phys(head_q, idx_q);
    raddr = phys(head_q, idx_q);
    wdata = new_entry;
    ov_d = ov_q && out_stall_i;
    ofv_d = ofv_q;  otag_d = otag_q;  oarg_d = oarg_q;  olast_d = olast_q;
    ost_d = ost_q;  ocmp_d = ocmp_q;  oarm_d = oarm_q;
    unique case (state_q)
      dotq_pkg::StIdle: begin
        if (accept) begin
          tgt_d = now_q + offset_i;
          tag_d = event_tag_i;
          arg_d = event_arg_i;
          idx_d = '0;
          wr_d  = '0;
          st_d  = 1'b0;
          case (dotq_pkg::action_e'(action_i))
            dotq_pkg::ActTick: now_d = now_q + 64'd1;
            dotq_pkg::ActAdd: begin
              st_d  = (occ_q == CW'(QueueDepth));
              idx_d = JW'(occ_q);
            end
            default: ;
          endcase
        end
      end
      dotq_pkg::StAddRd: begin
        if (idx_q == '0) begin
          we = 1'b1;
          occ_d = occ_q + CW'(1);
          cmp_d = pick_cmp(floor_q, tgt_q);
        end else begin
          re = 1'b1;
          raddr = phys(head_q, idx_q - JW'(1));
        end
      end
      dotq_pkg::StAddCmp: begin
        we = 1'b1;
        if (rdata_q.deadline > tgt_q) begin
          wdata = rdata_q;
          idx_d = idx_q - JW'(1);
        end else begin
          occ_d = occ_q + CW'(1);
        end
      end
      dotq_pkg::StClrRd: begin
        if (idx_q == JW'(occ_q)) begin
          occ_d = CW'(wr_q);
        end else begin
          re = 1'b1;
        end
      end
      dotq_pkg::StClrCmp: begin
        idx_d = idx_q + JW'(1);
        if (rdata_q.tag != tag_q) begin
          we = 1'b1;
          waddr = phys(head_q, wr_q);
          wdata = rdata_q;
          wr_d = wr_q + JW'(1);
        end
      end
      dotq_pkg::StTickRd: re = (idx_q != JW'(occ_q));
      dotq_pkg::StTickCmp: begin
        if (due) begin
          idx_d = idx_q + JW'(1);
        end else begin
          cmp_d = pick_cmp(floor_q, rdata_q.deadline);
        end
      end
      dotq_pkg::StEmitRd: begin
        if (idx_q != '0) begin
          re = 1'b1;
          raddr = phys(head_q, wr_q);
        end else if (can_load) begin
          ov_d = 1'b1;  ofv_d = 1'b0;  otag_d = '0;  oarg_d = '0;
          olast_d = 1'b1;  ost_d = 1'b0;  ocmp_d = cmp_q;
          oarm_d = (occ_q != '0);
        end
      end
      dotq_pkg::StEmitOut: begin
        if (can_load) begin
          ov_d = 1'b1;  ofv_d = 1'b1;
          otag_d = rdata_q.tag;  oarg_d = rdata_q.arg;
          olast_d = (wr_q == idx_q - JW'(1));
          ost_d = 1'b0;  ocmp_d = cmp_q;
          oarm_d = (JW'(occ_q) != idx_q);
          wr_d = wr_q + JW'(1);
          if (wr_q == idx_q - JW'(1)) begin
            // events fired: drop them from the head of the ring
            head_d = phys(head_q, idx_q);
            occ_d  = occ_q - CW'(idx_q);
          end
        end
      end
      dotq_pkg::StResp: begin
        if (can_load) begin
          ov_d = 1'b1;  ofv_d = 1'b0;  otag_d = '0;  oarg_d = '0;
          olast_d = 1'b1;  ost_d = st_q;  ocmp_d = cmp_q;
          oarm_d = (occ_q != '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dotq_pkg::StIdle;
      now_q   <= '0;
      floor_q <= '0;
      cmp_q   <= '0;
      min_q   <= dotq_pkg::MinIntervalRst;
      head_q  <= '0;
      occ_q   <= '0;
      idx_q   <= '0;
      wr_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      now_q   <= now_d;
      floor_q <= now_q + {48'd0, min_q};
      cmp_q   <= cmp_d;
      if (min_interval_we_i) begin
        min_q <= min_interval_i;
      end
      head_q  <= head_d;
      occ_q   <= occ_d;
      idx_q   <= idx_d;
      wr_q    <= wr_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q   <= tgt_d;
    tag_q   <= tag_d;
    arg_q   <= arg_d;
    st_q    <= st_d;
    ofv_q   <= ofv_d;
    otag_q  <= otag_d;
    oarg_q  <= oarg_d;
    olast_q <= olast_d;
    ost_q   <= ost_d;
    ocmp_q  <= ocmp_d;
    oarm_q  <= oarm_d;
  end

  assign out_valid_o     = ov_q;
  assign fired_valid_o   = ofv_q;
  assign fired_tag_o     = otag_q;
  assign fired_arg_o     = oarg_q;
  assign last_o          = olast_q;
  assign status_o        = ost_q;
  assign compare_value_o = ocmp_q;
  assign armed_o         = oarm_q;

endmodule
`default_nettype wire

FILE: design/dotq_checker.sv
`default_nettype none
module dotq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        fired_valid_o,
  input wire logic [7:0]  fired_tag_o,
  input wire logic [15:0] fired_arg_o,
  input wire logic        last_o,
  input wire logic        status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped under stall");

  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fired_valid_o |-> last_o)
    else $error("non-fired word not marked last");

  a_status_nofire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> !fired_valid_o && last_o)
    else $error("full status on a fired word");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fired_valid_o |-> fired_tag_o == 8'd0 && fired_arg_o == 16'd0)
    else $error("non-fired word carries event data");

endmodule

bind deadline_ordered_timer_queue_unit dotq_checker u_dotq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .fired_valid_o (fired_valid_o),
  .fired_tag_o   (fired_tag_o),
  .fired_arg_o   (fired_arg_o),
  .last_o        (last_o),
  .status_o      (status_o)
);
`default_nettype wire
